[hdl/nibble_bus_frame_receiver_top_assert.svh]
// Assertion macros for the nibble bus frame receiver.
// No dependencies; included by the modules that check their own logic.
`ifndef NIBBLE_BUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define NIBBLE_BUS_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTH
`define NBFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nbfr assertion failed");
`define NBFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nbfr assertion failed");
`else
`define NBFR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NBFR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/nbfr_pkg.sv]
// Shared types, codes and functions of the nibble bus frame receiver.
// No dependencies.
package nbfr_pkg;

    localparam int FRAME_LIMIT_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0]  EOT_NIBBLE       = 4'hF;
    localparam int          MIN_FRAME_BYTES  = 4;
    localparam logic [15:0] CRC_POLY         = 16'hA001;

    localparam logic [15:0] GLITCH_RST  = 16'd500;
    localparam logic [15:0] EOT_RST     = 16'd2500;
    localparam logic [10:0] MAXFRAME_RST = 11'd1024;
    localparam logic [2:0]  OWN_PIN_RST = 3'd4;

    typedef enum logic [1:0] {
        FUNC_START   = 2'd0,
        FUNC_EDGE    = 2'd1,
        FUNC_TIMEOUT = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        CFG_GLITCH   = 2'd0,
        CFG_EOT      = 2'd1,
        CFG_MAXFRAME = 2'd2,
        CFG_OWN_PIN  = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_EOT  = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_SHORT    = 3'd3,
        ST_LEN      = 3'd4,
        ST_CRC      = 3'd5,
        ST_TIMEOUT  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_EOT     = 2'd2,
        CMD_TIMEOUT = 2'd3
    } t_cmd_kind;

    typedef enum logic {
        KIND_BYTE   = 1'b0,
        KIND_STATUS = 1'b1
    } t_out_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [3:0] nibble;
    } t_cmd;

    localparam int CMD_W = $bits(t_cmd);

    function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'd0, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[hdl/nbfr_front.sv]
// Input side: configuration registers, event decode and glitch filtering.
// Depends on nbfr_pkg.
module nbfr_front
    import nbfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // edge_interval, nibble, requester_pin
    input  logic [1:0]  i_s_axis_tuser,  // func
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd,
    output logic [10:0] o_max_frame_bytes
);

    logic [15:0] r_glitch_min;
    logic [15:0] r_eot_min;
    logic [10:0] r_max_frame;
    logic [2:0]  r_own_pin;

    logic [15:0] interval;
    logic [3:0]  nibble;
    logic [1:0]  req_pin;
    logic        keep;
    logic        accept;

    assign interval = i_s_axis_tdata[15:0];
    assign nibble   = i_s_axis_tdata[19:16];
    assign req_pin  = i_s_axis_tdata[21:20];

    assign o_cfg_ready       = 1'b1;
    assign o_s_axis_tready   = !i_q_full;
    assign accept            = i_s_axis_tvalid && !i_q_full;
    assign o_max_frame_bytes = r_max_frame;

    always_comb begin
        keep           = 1'b0;
        o_q_cmd.kind   = CMD_DATA;
        o_q_cmd.nibble = nibble;
        case (i_s_axis_tuser)
            FUNC_START: begin
                o_q_cmd.kind = CMD_START;
                keep = r_own_pin[2] || (req_pin != r_own_pin[1:0]);
            end
            FUNC_EDGE: begin
                keep = (interval >= r_glitch_min);
                o_q_cmd.kind = (interval > r_eot_min) ? CMD_EOT : CMD_DATA;
            end
            FUNC_TIMEOUT: begin
                o_q_cmd.kind = CMD_TIMEOUT;
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_q_push = accept && keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_min <= GLITCH_RST;
            r_eot_min    <= EOT_RST;
            r_max_frame  <= MAXFRAME_RST;
            r_own_pin    <= OWN_PIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GLITCH:   r_glitch_min <= i_cfg_data;
                CFG_EOT:      r_eot_min    <= i_cfg_data;
                CFG_MAXFRAME: r_max_frame  <= i_cfg_data[10:0];
                CFG_OWN_PIN:  r_own_pin    <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[hdl/nbfr_fifo.sv]
// Short command queue between decode and frame processing.
// Depends on nbfr_pkg and the assertion macro header.
`include "nibble_bus_frame_receiver_top_assert.svh"
module nbfr_fifo
    import nbfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = CMD_W
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wr_ptr;
    logic [AW-1:0]    n_rd_ptr;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `NBFR_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)
    `NBFR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))

endmodule

[hdl/nbfr_back.sv]
// Frame processing: byte assembly, header and CRC checks, output register.
// Depends on nbfr_pkg and the assertion macro header.
`include "nibble_bus_frame_receiver_top_assert.svh"
module nbfr_back
    import nbfr_pkg::*;
#(
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  logic [10:0] i_max_frame_bytes,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // data_byte, byte_index, status
    output logic        o_m_axis_tuser   // out_kind
);

    localparam int BW = $clog2(FRAME_LIMIT + 1);

    logic          r_receiving;
    logic          r_low_next;
    logic [BW-1:0] r_byte_count;
    logic [7:0]    r_partial;
    logic [15:0]   r_header_len;
    logic [7:0]    r_delay0;
    logic [7:0]    r_delay1;
    logic [15:0]   r_crc;

    logic          r_out_valid;
    t_out_kind     r_out_kind;
    logic [7:0]    r_out_data;
    logic [9:0]    r_out_index;
    t_status       r_out_status;

    logic          take;
    logic [16:0]   limit;
    logic          at_limit;
    logic [7:0]    new_byte;
    logic [16:0]   idx_minus4;
    t_status       end_status;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_m_axis_tready);
    assign take    = o_q_pop;

    assign limit = (17'(i_max_frame_bytes) > 17'(FRAME_LIMIT)) ?
                   17'(FRAME_LIMIT) : 17'(i_max_frame_bytes);
    assign at_limit   = (17'(r_byte_count) >= limit);
    assign new_byte   = r_partial | {4'd0, i_q_cmd.nibble};
    assign idx_minus4 = 17'(r_byte_count) - 17'(MIN_FRAME_BYTES);

    always_comb begin
        if (i_q_cmd.nibble != EOT_NIBBLE) begin
            end_status = ST_BAD_EOT;
        end else if (17'(r_byte_count) < 17'(MIN_FRAME_BYTES)) begin
            end_status = ST_SHORT;
        end else if (r_header_len != 16'(r_byte_count)) begin
            end_status = ST_LEN;
        end else if ({r_delay1, r_delay0} != r_crc) begin
            end_status = ST_CRC;
        end else begin
            end_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_low_next   <= 1'b0;
            r_byte_count <= '0;
            r_partial    <= '0;
            r_header_len <= '0;
            r_delay0     <= '0;
            r_delay1     <= '0;
            r_crc        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (take) begin
                r_out_kind   <= KIND_STATUS;
                r_out_data   <= '0;
                r_out_index  <= '0;
                r_out_status <= ST_OK;
                case (i_q_cmd.kind)
                    CMD_START: begin
                        if (!r_receiving) begin
                            r_receiving  <= 1'b1;
                            r_low_next   <= 1'b0;
                            r_byte_count <= '0;
                            r_partial    <= '0;
                            r_header_len <= '0;
                            r_delay0     <= '0;
                            r_delay1     <= '0;
                            r_crc        <= '0;
                        end
                    end
                    CMD_TIMEOUT: begin
                        if (r_receiving) begin
                            r_receiving  <= 1'b0;
                            r_out_valid  <= 1'b1;
                            r_out_status <= ST_TIMEOUT;
                        end
                    end
                    CMD_EOT: begin
                        if (r_receiving) begin
                            r_receiving  <= 1'b0;
                            r_out_valid  <= 1'b1;
                            r_out_status <= end_status;
                        end
                    end
                    CMD_DATA: begin
                        if (r_receiving) begin
                            if (at_limit) begin
                                r_receiving  <= 1'b0;
                                r_out_valid  <= 1'b1;
                                r_out_status <= ST_OVERFLOW;
                            end else if (!r_low_next) begin
                                r_partial  <= {i_q_cmd.nibble, 4'd0};
                                r_low_next <= 1'b1;
                            end else begin
                                r_partial    <= new_byte;
                                r_low_next   <= 1'b0;
                                r_byte_count <= r_byte_count + 1'b1;
                                if (r_byte_count == '0) begin
                                    r_header_len[7:0] <= new_byte;
                                end else if (r_byte_count == BW'(1)) begin
                                    r_header_len[15:8] <= new_byte;
                                end else begin
                                    if (17'(r_byte_count) >= 17'(MIN_FRAME_BYTES)) begin
                                        r_out_valid <= 1'b1;
                                        r_out_kind  <= KIND_BYTE;
                                        r_out_data  <= r_delay0;
                                        r_out_index <= idx_minus4[9:0];
                                        r_crc       <= crc_arc_byte(r_crc, r_delay0);
                                    end
                                    r_delay0 <= r_delay1;
                                    r_delay1 <= new_byte;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {3'd0, r_out_status, r_out_index, r_out_data};

    `NBFR_ASSERT_NOW(a_status_fields, i_clk, i_rst_n,
        r_out_valid && (r_out_kind == KIND_STATUS),
        (r_out_data == '0) && (r_out_index == '0))
    `NBFR_ASSERT_NEXT(a_byte_after_header, i_clk, i_rst_n,
        take && r_receiving && r_low_next && !at_limit && (i_q_cmd.kind == CMD_DATA)
            && (17'(r_byte_count) >= 17'(MIN_FRAME_BYTES)),
        r_out_valid && (r_out_kind == KIND_BYTE) && (r_out_status == ST_OK))

endmodule

[hdl/nibble_bus_frame_receiver_top.sv]
// Nibble bus frame receiver. Takes one input event per clock cycle while the
// queue is not full and gives at most one result per event. A decode stage
// filters glitch edges and own-pin bus requests and writes commands into a
// four-entry queue; the frame stage takes one command per cycle whenever its
// output register is empty or being read, so a result passes the queue and
// the output register; the sustained rate is one event per cycle while the
// output side keeps up. Configuration writes must be made while idle.
// Depends on nbfr_pkg, nbfr_front, nbfr_fifo and nbfr_back.
module nibble_bus_frame_receiver_top
    import nbfr_pkg::*;
#(
    parameter int FRAME_LIMIT = FRAME_LIMIT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // edge_interval, nibble, requester_pin
    input  logic [1:0]  i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // data_byte, byte_index, status
    output logic        o_m_axis_tuser   // out_kind
);

    logic        q_full;
    logic        q_push;
    t_cmd        q_in;
    logic        q_pop;
    logic        q_valid;
    t_cmd        q_out;
    logic [10:0] max_frame_bytes;

    nbfr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (t_cfg_index'(i_cfg_index)),
        .i_cfg_data        (i_cfg_data),
        .i_s_axis_tvalid   (i_s_axis_tvalid),
        .o_s_axis_tready   (o_s_axis_tready),
        .i_s_axis_tdata    (i_s_axis_tdata),
        .i_s_axis_tuser    (i_s_axis_tuser),
        .i_q_full          (q_full),
        .o_q_push          (q_push),
        .o_q_cmd           (q_in),
        .o_max_frame_bytes (max_frame_bytes)
    );

    nbfr_fifo #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (CMD_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    nbfr_back #(
        .FRAME_LIMIT (FRAME_LIMIT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_cmd           (q_out),
        .o_q_pop           (q_pop),
        .i_max_frame_bytes (max_frame_bytes),
        .o_m_axis_tvalid   (o_m_axis_tvalid),
        .i_m_axis_tready   (i_m_axis_tready),
        .o_m_axis_tdata    (o_m_axis_tdata),
        .o_m_axis_tuser    (o_m_axis_tuser)
    );

endmodule
